// ===== src/tccs_pkg.sv =====
// tccs_pkg: shared types and constants for the text console cursor/scroll block
// used by tccs_ctrl, tccs_datapath and text_console_cursor_scroll; no dependencies
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int CMD_W        = 2;
    localparam int BYTE_W       = 8;
    localparam int INDEX_W      = 11;
    localparam int CURSOR_COL_W = 7;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_POS_W = 11;
    localparam int CELL_DATA_W  = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h17;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic exec;
        logic move;
        logic fill;
        logic init_attr;
        logic inc;
        logic load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic scroll_need;
        logic move_last;
        logic fill_last;
        logic out_free;
    } status_t;

endpackage

// ===== src/tccs_ctrl.sv =====
// tccs_ctrl: sequencer for request execution, scroll, clear and the reset clearing pass
// depends on tccs_pkg (cmd_t, ctrl_t, status_t)
`timescale 1ns / 1ps

module tccs_ctrl
    import tccs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output ctrl_t   ctrl
);

    typedef enum logic [6:0] {
        ST_INIT   = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_SCROLL = 7'b0010000,
        ST_FILL   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        ctrl       = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                ctrl.fill      = 1'b1;
                ctrl.init_attr = 1'b1;
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.take  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctrl.exec = 1'b1;
                unique case (status.cmd)
                    CMD_READ:
                    begin
                        state_next = ST_READ;
                    end
                    CMD_CLEAR:
                    begin
                        state_next = ST_FILL;
                    end
                    CMD_PUT, CMD_NONE:
                    begin
                        if (status.cmd == CMD_PUT && status.scroll_need)
                        begin
                            state_next = ST_SCROLL;
                        end
                        else if (status.out_free)
                        begin
                            ctrl.load  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ:
            begin
                if (status.out_free)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                ctrl.move = 1'b1;
                if (status.move_last)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    ctrl.inc = 1'b1;
                end
            end
            ST_FILL:
            begin
                ctrl.fill = 1'b1;
                if (status.fill_last)
                begin
                    if (status.out_free)
                    begin
                        ctrl.load  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    ctrl.inc = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ===== src/tccs_datapath.sv =====
// tccs_datapath: screen memory, cursor registers, sweep counter and result register
// depends on tccs_pkg; driven by tccs_ctrl through ctrl_t / status_t
`timescale 1ns / 1ps

module tccs_datapath
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [BYTE_W-1:0]       cfg_wdata,
    input  logic [CMD_W-1:0]        command,
    input  logic [BYTE_W-1:0]       char_code,
    input  logic [BYTE_W-1:0]       char_attr,
    input  logic [INDEX_W-1:0]      cell_index,
    input  ctrl_t                   ctrl,
    output status_t                 status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [BYTE_W-1:0]       read_char,
    output logic [BYTE_W-1:0]       read_attr,
    output logic [CURSOR_COL_W-1:0] cursor_col,
    output logic [CURSOR_ROW_W-1:0] cursor_row,
    output logic [CURSOR_POS_W-1:0] cursor_pos
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int MOVED  = (ROWS - 1) * COLUMNS;
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CELL_W = $clog2(CELLS);

    // latched request
    cmd_t                   cmd_reg;
    logic [BYTE_W-1:0]      char_reg;
    logic [BYTE_W-1:0]      attr_reg;
    logic [CELL_W-1:0]      index_reg;
    logic                   hit_reg;

    logic [COL_W-1:0]       col_reg;
    logic [COL_W-1:0]       col_next;
    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       row_next;
    logic [CELL_W-1:0]      pos_reg;
    logic [CELL_W-1:0]      pos_next;
    logic [CELL_W-1:0]      sweep_reg;
    logic [BYTE_W-1:0]      blank_attr_reg;

    logic [CELL_DATA_W-1:0] cells_mem [CELLS];
    logic [CELL_DATA_W-1:0] rd_data_reg;

    logic                    out_valid_reg;
    logic [BYTE_W-1:0]       read_char_reg;
    logic [BYTE_W-1:0]       read_attr_reg;
    logic [CURSOR_COL_W-1:0] cursor_col_reg;
    logic [CURSOR_ROW_W-1:0] cursor_row_reg;
    logic [CURSOR_POS_W-1:0] cursor_pos_reg;

    logic [31:0]            index_ext;
    logic [31:0]            col_ext;
    logic [31:0]            row_ext;
    logic [31:0]            pos_ext;
    logic                   is_newline;
    logic                   at_col_end;
    logic                   at_last_row;
    logic                   wrap;
    logic [CELL_W-1:0]      line_start;
    logic [CELL_W:0]        ahead_sum;
    logic                   wr_en;
    logic [CELL_W-1:0]      wr_addr;
    logic [CELL_DATA_W-1:0] wr_data;
    logic                   rd_en;
    logic [CELL_W-1:0]      rd_addr;
    logic [BYTE_W-1:0]      fill_attr;
    logic                   out_free;
    logic                   read_out;

    assign index_ext = 32'(cell_index);

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
        begin
            cmd_reg   <= cmd_t'(command);
            char_reg  <= char_code;
            attr_reg  <= char_attr;
            index_reg <= index_ext[CELL_W-1:0];
            hit_reg   <= (index_ext < 32'(CELLS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_attr_reg <= RESET_ATTR;
        end
        else if (cfg_we)
        begin
            blank_attr_reg <= cfg_wdata;
        end
    end

    // cursor update
    assign is_newline  = (char_reg == NEWLINE_CHAR);
    assign at_col_end  = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row = (row_reg == ROW_W'(ROWS - 1));
    assign wrap        = is_newline || at_col_end;
    assign line_start  = pos_reg - CELL_W'(col_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        pos_next = pos_reg;
        if (ctrl.exec)
        begin
            unique case (cmd_reg)
                CMD_PUT:
                begin
                    if (wrap)
                    begin
                        col_next = '0;
                        if (at_last_row)
                        begin
                            pos_next = line_start;
                        end
                        else
                        begin
                            row_next = row_reg + ROW_W'(1);
                            pos_next = line_start + CELL_W'(COLUMNS);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                        pos_next = pos_reg + CELL_W'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    col_next = '0;
                    row_next = '0;
                    pos_next = '0;
                end
                CMD_READ, CMD_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            pos_reg   <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            pos_reg <= pos_next;
            if (ctrl.exec)
            begin
                sweep_reg <= '0;
            end
            else if (ctrl.inc)
            begin
                sweep_reg <= sweep_reg + CELL_W'(1);
            end
        end
    end

    // memory port selection
    assign ahead_sum = (CELL_W + 1)'(sweep_reg) + (CELL_W + 1)'(COLUMNS);
    assign fill_attr = ctrl.init_attr ? RESET_ATTR : blank_attr_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = {BLANK_CHAR, fill_attr};
        rd_en   = 1'b0;
        rd_addr = ahead_sum[CELL_W-1:0];
        priority if (ctrl.exec)
        begin
            if (cmd_reg == CMD_PUT && !is_newline)
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                wr_data = {char_reg, attr_reg};
            end
            if (cmd_reg == CMD_READ && hit_reg)
            begin
                rd_en   = 1'b1;
                rd_addr = index_reg;
            end
        end
        else if (ctrl.move)
        begin
            wr_en   = (sweep_reg != '0);
            wr_addr = sweep_reg - CELL_W'(1);
            wr_data = rd_data_reg;
            rd_en   = !status.move_last;
        end
        else if (ctrl.fill)
        begin
            wr_en = 1'b1;
        end
        else
        begin
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cells_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cells_mem[rd_addr];
        end
    end

    // result register
    assign out_free = !out_valid_reg || !out_stall;
    assign read_out = (cmd_reg == CMD_READ) && hit_reg;
    assign col_ext  = 32'(col_next);
    assign row_ext  = 32'(row_next);
    assign pos_ext  = 32'(pos_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctrl.load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            read_char_reg  <= read_out ? rd_data_reg[CELL_DATA_W-1:BYTE_W] : '0;
            read_attr_reg  <= read_out ? rd_data_reg[BYTE_W-1:0] : '0;
            cursor_col_reg <= col_ext[CURSOR_COL_W-1:0];
            cursor_row_reg <= row_ext[CURSOR_ROW_W-1:0];
            cursor_pos_reg <= pos_ext[CURSOR_POS_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_char  = read_char_reg;
    assign read_attr  = read_attr_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_pos = cursor_pos_reg;

    assign status.cmd         = cmd_reg;
    assign status.scroll_need = wrap && at_last_row;
    assign status.move_last   = (sweep_reg == CELL_W'(MOVED));
    assign status.fill_last   = (sweep_reg == CELL_W'(CELLS - 1));
    assign status.out_free    = out_free;

    // a result is never loaded over one that is still held
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |-> out_free)
    else $error("result loaded over a stalled result");

    // linear cursor position tracks row and column
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) == 32'(row_reg) * 32'(COLUMNS) + 32'(col_reg))
    else $error("cursor position out of step with row and column");

    // cursor stays on the screen
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS)))
    else $error("cursor off screen");

endmodule

// ===== src/text_console_cursor_scroll.sv =====
// text_console_cursor_scroll: top level of the text console engine
// depends on tccs_pkg, tccs_ctrl and tccs_datapath
`timescale 1ns / 1ps

// Text console engine holding a ROWS x COLUMNS screen of character/attribute
// cells and a cursor. Requests enter on in_valid/in_stall, one at a time;
// each gives one result on out_valid/out_stall, and a new request is taken
// while an earlier result still waits in the output register. A put or an
// unused command passes through accept and execute; a read also waits for
// the screen memory read, which is registered. A put that runs past the last
// row scrolls: the row moves and the blanking of the bottom row follow the
// put itself; a clear blanks every cell of the screen. These walks go
// through the single write port of the screen memory, one cell per cycle.
// After reset a clearing pass blanks the screen with attribute 0x17 while
// in_stall stays high; cfg_we writes of blank_attr are taken at any time.
module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [BYTE_W-1:0]       cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CMD_W-1:0]        command,
    input  logic [BYTE_W-1:0]       char_code,
    input  logic [BYTE_W-1:0]       char_attr,
    input  logic [INDEX_W-1:0]      cell_index,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [BYTE_W-1:0]       read_char,
    output logic [BYTE_W-1:0]       read_attr,
    output logic [CURSOR_COL_W-1:0] cursor_col,
    output logic [CURSOR_ROW_W-1:0] cursor_row,
    output logic [CURSOR_POS_W-1:0] cursor_pos
);

    ctrl_t   ctrl;
    status_t status;

    tccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .ctrl     (ctrl)
    );

    tccs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .command    (command),
        .char_code  (char_code),
        .char_attr  (char_attr),
        .cell_index (cell_index),
        .ctrl       (ctrl),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_char  (read_char),
        .read_attr  (read_attr),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cursor_pos (cursor_pos)
    );

endmodule
